// ===== src/radix_prefixed_number_parser_core_assert.svh =====
// ----------------------------------------------------------------------------
// Radix prefixed number parser assertion macros
// Shared concurrent assertion forms for the parser modules.
// ----------------------------------------------------------------------------
`ifndef RADIX_PREFIXED_NUMBER_PARSER_CORE_ASSERT_SVH
`define RADIX_PREFIXED_NUMBER_PARSER_CORE_ASSERT_SVH

// condition must hold on the same edge
`define RPNP_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rpnp assertion failed");

// condition must hold on the following edge
`define RPNP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rpnp assertion failed");

`endif

// ===== src/rpnp_pkg.sv =====
// ----------------------------------------------------------------------------
// Radix prefixed number parser package
// Character codes, radix codes, token phase type and shared helpers.
// ----------------------------------------------------------------------------
package rpnp_pkg;

   localparam int unsigned ValueWidth = 32;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_CASE_OFS = 8'h20;
   localparam logic [7:0] CHAR_LOWER_B = 8'h62;
   localparam logic [7:0] CHAR_LOWER_Q = 8'h71;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;
   // 'a' - 10
   localparam logic signed [8:0] ALPHA_DIGIT_OFS = 9'sd87;

   localparam logic [2:0] RADIX_DEC  = 3'd0;
   localparam logic [2:0] RADIX_BIN  = 3'd1;
   localparam logic [2:0] RADIX_QUAD = 3'd2;
   localparam logic [2:0] RADIX_HEX  = 3'd3;
   localparam logic [2:0] RADIX_OCT  = 3'd4;

   typedef enum logic [2:0] {
      PHASE_FIRST  = 3'b001,
      PHASE_SECOND = 3'b010,
      PHASE_DIGITS = 3'b100
   } phase_type;

   typedef struct packed {
      logic signed [8:0] digit;
      logic [7:0]        lower;
   } digit_info_type;

   typedef struct packed {
      logic                  valid;
      logic [ValueWidth-1:0] value;
      logic [2:0]            radix_code;
      logic                  digit_error;
      logic [7:0]            bad_char;
   } result_type;

   function automatic logic [4:0] radix_base(input logic [2:0] radix);
      logic [4:0] base;
      case (radix)
         RADIX_BIN:  base = 5'd2;
         RADIX_QUAD: base = 5'd4;
         RADIX_HEX:  base = 5'd16;
         RADIX_OCT:  base = 5'd8;
         default:    base = 5'd10;
      endcase
      return base;
   endfunction

   // acc * base with shifts and an add, wrapping at the value width
   function automatic logic [ValueWidth-1:0] scale_by_radix(
      input logic [ValueWidth-1:0] acc,
      input logic [2:0]            radix
   );
      logic [ValueWidth-1:0] res;
      case (radix)
         RADIX_BIN:  res = acc << 1;
         RADIX_QUAD: res = acc << 2;
         RADIX_HEX:  res = acc << 4;
         RADIX_OCT:  res = acc << 3;
         default:    res = (acc << 3) + (acc << 1);
      endcase
      return res;
   endfunction

endpackage

// ===== src/rpnp_digit.sv =====
// ----------------------------------------------------------------------------
// Radix prefixed number parser digit decode
// Folds letter case and maps a character to its signed digit value.
// ----------------------------------------------------------------------------
module rpnp_digit (
   input  logic [7:0]              char_code,
   output rpnp_pkg::digit_info_type info
);

   logic [7:0] lower;

   always_comb begin
      case (char_code) inside
         [rpnp_pkg::CHAR_UPPER_A : rpnp_pkg::CHAR_UPPER_Z]: begin
            lower = char_code + rpnp_pkg::CHAR_CASE_OFS;
         end
         default: begin
            lower = char_code;
         end
      endcase
   end

   always_comb begin
      info.lower = lower;
      case (char_code) inside
         [rpnp_pkg::CHAR_ZERO : rpnp_pkg::CHAR_NINE]: begin
            info.digit = $signed({1'b0, char_code - rpnp_pkg::CHAR_ZERO});
         end
         default: begin
            // non-decimal codes below 0x57, uppercase letters aside, come out negative
            info.digit = $signed({1'b0, lower}) - rpnp_pkg::ALPHA_DIGIT_OFS;
         end
      endcase
   end

endmodule

// ===== src/rpnp_accum.sv =====
// ----------------------------------------------------------------------------
// Radix prefixed number parser accumulator
// Token state registers: prefix phase, radix, running value, error capture.
// ----------------------------------------------------------------------------
`include "radix_prefixed_number_parser_core_assert.svh"

module rpnp_accum #(
   parameter int unsigned MAX_TOKEN_CHARS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              char_code,
   input  logic                    last,
   input  rpnp_pkg::digit_info_type info,
   output rpnp_pkg::result_type    result
);

   localparam int unsigned CntW = $clog2(MAX_TOKEN_CHARS + 1);
   localparam int unsigned VW   = rpnp_pkg::ValueWidth;

   rpnp_pkg::phase_type phase_ff, phase_in;
   logic [2:0]          radix_ff, radix_in;
   logic [VW-1:0]       acc_ff, acc_in;
   logic                err_ff, err_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic [7:0]          bad_ff, bad_in;

   logic          take_char;
   logic          take_digit;
   logic [2:0]    radix_eff;
   logic [4:0]    base;
   logic          digit_bad;
   logic [VW-1:0] acc_step;

   assign take_char = count_ff < CntW'(MAX_TOKEN_CHARS);

   always_comb begin
      phase_in   = phase_ff;
      radix_in   = radix_ff;
      take_digit = 1'b0;
      radix_eff  = radix_ff;
      if (take_char) begin
         case (phase_ff)
            rpnp_pkg::PHASE_FIRST: begin
               if (char_code == rpnp_pkg::CHAR_ZERO) begin
                  radix_in = rpnp_pkg::RADIX_OCT;
                  phase_in = rpnp_pkg::PHASE_SECOND;
               end else begin
                  radix_in   = rpnp_pkg::RADIX_DEC;
                  radix_eff  = rpnp_pkg::RADIX_DEC;
                  phase_in   = rpnp_pkg::PHASE_DIGITS;
                  take_digit = 1'b1;
               end
            end
            rpnp_pkg::PHASE_SECOND: begin
               phase_in = rpnp_pkg::PHASE_DIGITS;
               case (info.lower)
                  rpnp_pkg::CHAR_LOWER_B: radix_in = rpnp_pkg::RADIX_BIN;
                  rpnp_pkg::CHAR_LOWER_Q: radix_in = rpnp_pkg::RADIX_QUAD;
                  rpnp_pkg::CHAR_LOWER_X: radix_in = rpnp_pkg::RADIX_HEX;
                  default:                take_digit = 1'b1;
               endcase
            end
            default: begin
               take_digit = 1'b1;
            end
         endcase
      end
   end

   assign base      = rpnp_pkg::radix_base(radix_eff);
   assign digit_bad = info.digit >= $signed({4'b0, base});
   assign acc_step  = rpnp_pkg::scale_by_radix(acc_ff, radix_eff)
                      + VW'(unsigned'(VW'(info.digit)));

   always_comb begin
      acc_in   = acc_ff;
      err_in   = err_ff;
      bad_in   = bad_ff;
      count_in = count_ff;
      if (take_char) begin
         count_in = count_ff + 1'b1;
      end
      if (take_digit && !err_ff) begin
         if (digit_bad) begin
            err_in = 1'b1;
            bad_in = char_code;
            acc_in = '0;
         end else begin
            acc_in = acc_step;
         end
      end
   end

   always_comb begin
      result.valid       = step && last;
      result.value       = err_in ? '0 : acc_in;
      result.radix_code  = radix_in;
      result.digit_error = err_in;
      result.bad_char    = err_in ? bad_in : 8'h00;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rpnp_pkg::PHASE_FIRST;
         radix_ff <= rpnp_pkg::RADIX_DEC;
         acc_ff   <= '0;
         err_ff   <= 1'b0;
         count_ff <= '0;
         bad_ff   <= '0;
      end else if (step) begin
         if (last) begin
            // token done, back to the idle token state
            phase_ff <= rpnp_pkg::PHASE_FIRST;
            radix_ff <= rpnp_pkg::RADIX_DEC;
            acc_ff   <= '0;
            err_ff   <= 1'b0;
            count_ff <= '0;
            bad_ff   <= '0;
         end else begin
            phase_ff <= phase_in;
            radix_ff <= radix_in;
            acc_ff   <= acc_in;
            err_ff   <= err_in;
            count_ff <= count_in;
            bad_ff   <= bad_in;
         end
      end
   end

   `RPNP_ASSERT_IMPLIES(a_err_clears_acc, clock, reset, err_ff, acc_ff == '0)
   `RPNP_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1,
                        count_ff <= CntW'(MAX_TOKEN_CHARS))
   `RPNP_ASSERT_IMPLIES(a_first_is_clean, clock, reset,
                        phase_ff == rpnp_pkg::PHASE_FIRST,
                        count_ff == '0 && !err_ff && radix_ff == rpnp_pkg::RADIX_DEC)
   `RPNP_ASSERT_NEXT(a_last_resets, clock, reset, step && last,
                     phase_ff == rpnp_pkg::PHASE_FIRST)

endmodule

// ===== src/radix_prefixed_number_parser_core.sv =====
// ----------------------------------------------------------------------------
// Radix prefixed number parser core
// Parses a numeric token with an optional 0b/0q/0x/0 radix prefix.
// ----------------------------------------------------------------------------
// Characters of one token arrive on req_ (valid/ready), one item each, with
// req_last marking the final character. Each token gives one result item on
// rsp_ (valid/ready): the wrapped 32-bit value, the radix code, a digit error
// flag and the first rejected character. Only the first MAX_TOKEN_CHARS
// characters count; later ones are dropped but a last mark still ends the
// token.
// A character taken on req_ goes into the input register; its token's result
// then goes into the result register that drives rsp_. One character per cycle
// is taken unless a character with last set is held; the shift-add accumulate
// step is combinational. Reset clears the token state and the valid flags of
// both registers; req_ready is high once reset has cleared the input register.
// While rsp_ready is low the result waits in its register; characters that end
// no token keep flowing, and a character with last set holds in the input
// register until the result register frees.
// ----------------------------------------------------------------------------
`include "radix_prefixed_number_parser_core_assert.svh"

module radix_prefixed_number_parser_core #(
   parameter int unsigned MAX_TOKEN_CHARS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_value,
   output logic [2:0]  rsp_radix_code,
   output logic        rsp_digit_error,
   output logic [7:0]  rsp_bad_char
);

   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       in_last_ff;
   logic       advance;

   rpnp_pkg::digit_info_type info;
   rpnp_pkg::result_type     result;
   rpnp_pkg::result_type     rsp_ff, rsp_in;

   assign advance   = in_valid_ff && (!in_last_ff || !rsp_ff.valid || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_code;
         in_last_ff <= req_last;
      end
   end

   rpnp_digit u_digit (
      .char_code (in_char_ff),
      .info      (info)
   );

   rpnp_accum #(
      .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .char_code (in_char_ff),
      .last      (in_last_ff),
      .info      (info),
      .result    (result)
   );

   always_comb begin
      rsp_in = rsp_ff;
      if (result.valid) begin
         rsp_in = result;
      end else if (rsp_ready) begin
         rsp_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else begin
         rsp_ff.valid <= rsp_in.valid;
      end
      rsp_ff.value       <= rsp_in.value;
      rsp_ff.radix_code  <= rsp_in.radix_code;
      rsp_ff.digit_error <= rsp_in.digit_error;
      rsp_ff.bad_char    <= rsp_in.bad_char;
   end

   assign rsp_valid       = rsp_ff.valid;
   assign rsp_value       = $signed(rsp_ff.value);
   assign rsp_radix_code  = rsp_ff.radix_code;
   assign rsp_digit_error = rsp_ff.digit_error;
   assign rsp_bad_char    = rsp_ff.bad_char;

   `RPNP_ASSERT_IMPLIES(a_ok_no_bad_char, clock, reset,
                        rsp_ff.valid && !rsp_ff.digit_error, rsp_ff.bad_char == 8'h00)
   `RPNP_ASSERT_IMPLIES(a_err_value_zero, clock, reset,
                        rsp_ff.valid && rsp_ff.digit_error, rsp_ff.value == '0)
   `RPNP_ASSERT_IMPLIES(a_no_overwrite, clock, reset,
                        result.valid, !rsp_ff.valid || rsp_ready)

endmodule
